@@ rtl/core/lct_pkg.sv @@
// lct_pkg: sizes, controller states and command/status structs shared by
// the linear complexity test block. No dependencies.
package lct_pkg;

  // longest block and the word width of the polynomial and history stores
  localparam int MAX_BLOCK  = 4096;
  localparam int WORD_W     = 64;
  localparam int WORD_SH    = $clog2(WORD_W);
  localparam int POS_W      = $clog2(MAX_BLOCK) + 1;
  localparam int Q_W        = $clog2(MAX_BLOCK);
  localparam int HIST_TOP   = MAX_BLOCK - 1;
  localparam int POLY_WORDS = MAX_BLOCK / WORD_W + 1;
  localparam int HIST_WORDS = MAX_BLOCK / WORD_W + 2;
  localparam int ADDR_W     = $clog2(HIST_WORDS);

  // register and result field widths
  localparam int LEN_W     = 13;
  localparam int LEN_RESET = 500;
  localparam int LEN_MIN   = 2;
  localparam int CNT_W     = 32;
  localparam int NUM_CLS   = 7;
  localparam int CLS_W     = 3;
  localparam int CLS_MAX   = NUM_CLS - 1;
  localparam int CLS_OFS   = 3;

  // three polynomial banks rotate between connection, previous and spare
  localparam int NUM_BANKS = 3;
  localparam int BANK_W    = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HIST,
    ST_DISC,
    ST_DISC_WAIT,
    ST_DEC,
    ST_UPD,
    ST_UPD_WAIT,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic hist_wr;
    logic disc_issue;
    logic upd_start;
    logic upd_issue;
    logic commit;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic disc_bit;
    logic blk_end;
    logic out_free;
  } ctl_sts_t;

endpackage

@@ rtl/core/block_linear_complexity_test.sv @@
// Linear complexity test over a bit stream: one bit per input transfer, one
// result per completed block of block_len bits (clamped to 2..4096). From one
// input transfer to the next a bit passes the history write, the discrepancy
// walk, the update walk when the discrepancy is one, and the commit, plus the
// result step at a block end; the walks grow with n, the position in the
// block, and L, the current complexity: the connection polynomial is walked
// 64 taps per cycle, one word read per store each cycle. No clearing pass
// after reset. The result waits in an output register while the next bit is
// taken; cfg_ready is high only while no bit is in work and none is offered.
// Uses lct_pkg, lct_ctrl and lct_dp.
module block_linear_complexity_test
  import lct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_seq_bit,
  input  logic             in_seq_start,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LEN_W-1:0] out_lin_complexity,
  output logic [CLS_W-1:0] out_bin_index,
  output logic [CNT_W-1:0] out_bin_count,
  output logic [CNT_W-1:0] out_block_number,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer
  lct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  lct_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_seq_bit         (in_seq_bit),
    .in_seq_start       (in_seq_start),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_lin_complexity (out_lin_complexity),
    .out_bin_index      (out_bin_index),
    .out_bin_count      (out_bin_count),
    .out_block_number   (out_block_number)
  );

`ifndef SYNTHESIS
  // one bit in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a bit is in flight");

  // class stays within the seven bins
  a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bin_index <= CLS_W'(CLS_MAX))
    else $error("class out of range");

  // a new result only follows an input transfer's work
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in progress");
`endif

endmodule

@@ rtl/core/lct_ram.sv @@
// lct_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module lct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/lct_ctrl.sv @@
// lct_ctrl: sequencer for one bit of Berlekamp-Massey: history write,
// discrepancy walk, polynomial update walk, commit and result. Uses lct_pkg.
module lct_ctrl
  import lct_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     cfg_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_HIST;
      ST_HIST:      state_nxt = ST_DISC;
      ST_DISC:      if (sts.cnt_last) state_nxt = ST_DISC_WAIT;
      ST_DISC_WAIT: state_nxt = ST_DEC;
      ST_DEC:       state_nxt = sts.disc_bit ? ST_UPD : ST_FIN;
      ST_UPD:       if (sts.cnt_last) state_nxt = ST_UPD_WAIT;
      ST_UPD_WAIT:  state_nxt = ST_FIN;
      ST_FIN:       state_nxt = sts.blk_end ? ST_OUT : ST_IDLE;
      ST_OUT:       if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = !in_valid;
        cmd.load  = in_valid;
      end
      ST_HIST:      cmd.hist_wr    = 1'b1;
      ST_DISC:      cmd.disc_issue = 1'b1;
      ST_DISC_WAIT: cmd            = '0;
      ST_DEC:       cmd.upd_start  = sts.disc_bit;
      ST_UPD:       cmd.upd_issue  = 1'b1;
      ST_UPD_WAIT:  cmd            = '0;
      ST_FIN:       cmd.commit     = 1'b1;
      ST_OUT:       cmd.emit       = sts.out_free;
      default:      cmd            = '0;
    endcase
  end

endmodule

@@ rtl/core/lct_dp.sv @@
// lct_dp: datapath of the linear complexity test: history and polynomial
// word stores, discrepancy and update units, class counters, result register.
// Uses lct_pkg and lct_ram.
module lct_dp
  import lct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  output ctl_sts_t          sts,
  input  logic              in_seq_bit,
  input  logic              in_seq_start,
  input  logic              cfg_wr,
  input  logic [LEN_W-1:0]  cfg_data,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [LEN_W-1:0]  out_lin_complexity,
  output logic [CLS_W-1:0]  out_bin_index,
  output logic [CNT_W-1:0]  out_bin_count,
  output logic [CNT_W-1:0]  out_block_number
);

  // a word never written since the block began reads as the reset polynomial
  function automatic logic [WORD_W-1:0] word_fix(input logic [WORD_W-1:0] d,
                                                 input logic v, input logic z);
    word_fix = v ? d : (z ? WORD_W'(1) : '0);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

  logic [LEN_W-1:0]  blk_len_r;
  logic [POS_W-1:0]  pos_r, n_r, lc_r, mp1_r;
  logic              bit_r;
  logic [WORD_W-1:0] hw_r, hw_nxt, prev_r;
  logic [ADDR_W-1:0] cnt_r, lim_r, kd_r;
  logic              acc_r, rdv_r, rupd_r;
  logic              cv_r, cz_r, bv_r, bz_r, bneg_r;
  logic [NUM_BANKS-1:0][POLY_WORDS-1:0] vld_r;
  logic [BANK_W-1:0] c_r, b_r, f_r;
  logic [CNT_W-1:0]  cls_cnt_r [NUM_CLS];
  logic [CNT_W-1:0]  blocks_r;
  logic              out_valid_r;
  logic [LEN_W-1:0]  out_lc_r;
  logic [CLS_W-1:0]  out_cls_r;
  logic [CNT_W-1:0]  out_cnt_r, out_blk_r;

  // effective block length
  logic [POS_W-1:0] len_eff;
  always_comb begin
    if (32'(blk_len_r) < LEN_MIN) begin
      len_eff = POS_W'(LEN_MIN);
    end else if (32'(blk_len_r) > MAX_BLOCK) begin
      len_eff = POS_W'(MAX_BLOCK);
    end else begin
      len_eff = POS_W'(blk_len_r);
    end
  end

  // history is stored reversed so that s[n-i] lines up with tap i
  logic [Q_W-1:0]            q;
  logic [Q_W-WORD_SH-1:0]    rb;
  logic [WORD_SH-1:0]        ro;
  assign q  = Q_W'(HIST_TOP) - Q_W'(n_r);
  assign rb = q[Q_W-1:WORD_SH];
  assign ro = q[WORD_SH-1:0];

  always_comb begin
    hw_nxt     = (&ro) ? '0 : hw_r;
    hw_nxt[ro] = bit_r;
  end

  // update shift n - m, split into word and bit parts
  logic [POS_W-1:0]         n_p1, shift;
  logic [POS_W-WORD_SH-1:0] sw;
  logic [WORD_SH-1:0]       sb;
  assign n_p1  = n_r + POS_W'(1);
  assign shift = n_p1 - mp1_r;
  assign sw    = shift[POS_W-1:WORD_SH];
  assign sb    = shift[WORD_SH-1:0];

  // read addresses for the current issue step
  logic [ADDR_W-1:0] r_raddr, c_addr, b_addr;
  logic [ADDR_W:0]   bdiff;
  assign r_raddr = ADDR_W'(rb) + cnt_r;
  assign c_addr  = cmd.upd_issue ? cnt_r : cnt_r - ADDR_W'(1);
  assign bdiff   = {1'b0, cnt_r} - {1'b0, ADDR_W'(sw)};
  assign b_addr  = bdiff[ADDR_W-1:0];

  logic c_ok, b_ok;
  assign c_ok = (32'(c_addr) < POLY_WORDS) && vld_r[c_r][c_addr];
  assign b_ok = (32'(b_addr) < POLY_WORDS) && vld_r[b_r][b_addr];

  // history store
  logic [WORD_W-1:0] r_rd;
  lct_ram #(.WIDTH(WORD_W), .DEPTH(HIST_WORDS)) u_hist (
    .clk   (clk),
    .we    (cmd.hist_wr),
    .waddr (ADDR_W'(rb)),
    .wdata (hw_nxt),
    .raddr (r_raddr),
    .rdata (r_rd)
  );

  // polynomial banks
  logic                                 wr_en;
  logic [WORD_W-1:0]                    new_c;
  logic [NUM_BANKS-1:0][WORD_W-1:0]     bank_rd;
  assign wr_en = rdv_r & rupd_r;

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    lct_ram #(.WIDTH(WORD_W), .DEPTH(POLY_WORDS)) u_poly (
      .clk   (clk),
      .we    (wr_en && (f_r == BANK_W'(g))),
      .waddr (kd_r),
      .wdata (new_c),
      .raddr ((c_r == BANK_W'(g)) ? c_addr : b_addr),
      .rdata (bank_rd[g])
    );
  end

  // word compute: discrepancy taps and shifted previous polynomial
  logic [WORD_W-1:0]   c_eff, b_eff, r_word, b_shift;
  logic [2*WORD_W-1:0] r_cat, b_cat;
  logic [WORD_SH:0]    b_lo;
  assign c_eff   = word_fix(bank_rd[c_r], cv_r, cz_r);
  assign b_eff   = bneg_r ? '0 : word_fix(bank_rd[b_r], bv_r, bz_r);
  assign r_cat   = {r_rd, prev_r};
  assign r_word  = r_cat[ro +: WORD_W];
  assign b_cat   = {b_eff, prev_r};
  assign b_lo    = (WORD_SH+1)'(WORD_W) - {1'b0, sb};
  assign b_shift = b_cat[b_lo +: WORD_W];
  assign new_c   = c_eff ^ b_shift;

  // block end class, exact integer form
  logic signed [POS_W+1:0] cls_s;
  logic [POS_W:0]          len7;
  logic [CLS_W-1:0]        cls;
  assign len7 = {1'b0, len_eff} + (POS_W+1)'(7);
  always_comb begin
    if (!len_eff[0]) begin
      cls_s = $signed({2'b0, lc_r}) - $signed({3'b0, len_eff[POS_W-1:1]})
            + (POS_W+2)'(CLS_OFS);
    end else begin
      cls_s = $signed({2'b0, len7[POS_W:1]}) - $signed({2'b0, lc_r});
    end
    if (cls_s < 0) begin
      cls = '0;
    end else if (cls_s > (POS_W+2)'(CLS_MAX)) begin
      cls = CLS_W'(CLS_MAX);
    end else begin
      cls = cls_s[CLS_W-1:0];
    end
  end

  logic [CNT_W-1:0] cls_inc, blk_inc;
  assign cls_inc = sat_inc(cls_cnt_r[cls]);
  assign blk_inc = sat_inc(blocks_r);

  logic start_now;
  assign start_now = in_seq_start || (pos_r >= len_eff);

  // status to the controller
  assign sts.cnt_last = (cnt_r == lim_r);
  assign sts.disc_bit = acc_r;
  assign sts.blk_end  = (n_p1 == len_eff);
  assign sts.out_free = !out_valid_r || !out_stall;

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_len_r   <= LEN_W'(LEN_RESET);
      pos_r       <= '0;
      lc_r        <= '0;
      mp1_r       <= '0;
      vld_r       <= '0;
      c_r         <= BANK_W'(0);
      b_r         <= BANK_W'(1);
      f_r         <= BANK_W'(2);
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      blocks_r    <= '0;
      for (int i = 0; i < NUM_CLS; i++) begin
        cls_cnt_r[i] <= '0;
      end
    end else begin
      // read data returns in the cycle after each issue step
      rdv_r <= cmd.disc_issue || cmd.upd_issue;

      // register write restarts the block
      if (cfg_wr) begin
        blk_len_r <= cfg_data;
        pos_r     <= '0;
        lc_r      <= '0;
        mp1_r     <= '0;
        vld_r     <= '0;
      end

      // input transfer
      if (cmd.load) begin
        bit_r <= in_seq_bit;
        n_r   <= start_now ? '0 : pos_r;
        if (start_now) begin
          lc_r  <= '0;
          mp1_r <= '0;
          vld_r <= '0;
        end
        if (in_seq_start) begin
          blocks_r <= '0;
          for (int i = 0; i < NUM_CLS; i++) begin
            cls_cnt_r[i] <= '0;
          end
        end
      end

      // history write, then set up the discrepancy walk
      if (cmd.hist_wr) begin
        hw_r  <= hw_nxt;
        cnt_r <= '0;
        lim_r <= ADDR_W'(lc_r >> WORD_SH) + ADDR_W'(1);
        acc_r <= 1'b0;
      end

      if (cmd.disc_issue) begin
        cnt_r  <= cnt_r + ADDR_W'(1);
        rupd_r <= 1'b0;
        kd_r   <= cnt_r;
        cv_r   <= c_ok;
        cz_r   <= (c_addr == '0);
      end

      if (cmd.upd_start) begin
        cnt_r     <= '0;
        lim_r     <= ADDR_W'(n_p1 >> WORD_SH);
        prev_r    <= '0;
        vld_r[f_r] <= '0;
      end

      if (cmd.upd_issue) begin
        cnt_r  <= cnt_r + ADDR_W'(1);
        rupd_r <= 1'b1;
        kd_r   <= cnt_r;
        cv_r   <= c_ok;
        cz_r   <= (c_addr == '0);
        bv_r   <= b_ok;
        bz_r   <= (b_addr == '0);
        bneg_r <= bdiff[ADDR_W];
      end

      // returning read data
      if (rdv_r) begin
        if (rupd_r) begin
          prev_r           <= b_eff;
          vld_r[f_r][kd_r] <= 1'b1;
        end else begin
          prev_r <= r_rd;
          if (kd_r != '0) begin
            acc_r <= acc_r ^ (^(c_eff & r_word));
          end
        end
      end

      // commit the bit: bank rotation and length change
      if (cmd.commit) begin
        pos_r <= n_p1;
        if (acc_r) begin
          c_r <= f_r;
          if (lc_r <= (n_r >> 1)) begin
            b_r   <= c_r;
            f_r   <= b_r;
            lc_r  <= n_p1 - lc_r;
            mp1_r <= n_p1;
          end else begin
            f_r <= c_r;
          end
        end
      end

      // result transfer out
      if (cmd.emit) begin
        out_valid_r    <= 1'b1;
        out_lc_r       <= LEN_W'(lc_r);
        out_cls_r      <= cls;
        out_cnt_r      <= cls_inc;
        out_blk_r      <= blk_inc;
        cls_cnt_r[cls] <= cls_inc;
        blocks_r       <= blk_inc;
        pos_r          <= '0;
        lc_r           <= '0;
        mp1_r          <= '0;
        vld_r          <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_lin_complexity = out_lc_r;
  assign out_bin_index      = out_cls_r;
  assign out_bin_count      = out_cnt_r;
  assign out_block_number   = out_blk_r;

endmodule
